>>> hw/rtl/rtsp_pkg.sv
package rtsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = 7;
    localparam int NIDX_W    = 6;
    localparam int EIDX_W    = 10;
    localparam int ECNT_W    = 11;
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 22;
    localparam int TOTAL_W   = 29;
    localparam int EDGE_W    = 2 * NODE_W + WEIGHT_W;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [DIST_W-1:0]  dist_there;
        logic [DIST_W-1:0]  dist_back;
        logic               there_reached;
        logic               back_reached;
        logic [TOTAL_W-1:0] round_trip_total;
        logic               edge_overflow;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SCAN_END,
        ST_EDGE,
        ST_EDGE_WAIT,
        ST_EDGE_END,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;        // mark only the start node reached and clear done marks for the pass
        logic scan;        // read node scan_idx for the minimum search
        logic scan_end;    // commit the chosen node as done
        logic edge_rd;     // read edge edge_idx
        logic edge_relax;  // look up the edge read in the previous cycle
        logic out_rd;      // read both distances of node out_idx
        logic out_load;    // load the result register
        logic rev;
    } cmd_t;

    typedef struct packed {
        logic found;       // a node was picked by the last scan
        logic out_full;
    } stat_t;

endpackage

>>> hw/rtl/rtsp_if.sv
interface rtsp_in_if;
    import rtsp_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtsp_out_if;
    import rtsp_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rtsp_ram.sv
module rtsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/rtsp_ctrl.sv
module rtsp_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rtsp_pkg::NODE_W-1:0] n,
    input  logic [rtsp_pkg::ECNT_W-1:0] edge_total,
    input  rtsp_pkg::stat_t            stat,
    output rtsp_pkg::cmd_t             cmd,
    output logic                       busy,
    output logic [rtsp_pkg::NIDX_W-1:0] scan_idx,
    output logic [rtsp_pkg::EIDX_W-1:0] edge_idx,
    output logic [rtsp_pkg::NIDX_W-1:0] out_idx,
    output logic                       out_last
);
    import rtsp_pkg::*;

    state_t            state_reg, state_next;
    logic              rev_reg, rev_next;
    logic [NODE_W-1:0] cnt_reg, cnt_next;
    logic [NODE_W-1:0] iter_reg, iter_next;
    logic [ECNT_W-1:0] ecnt_reg, ecnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rev_reg   <= 1'b0;
            cnt_reg   <= '0;
            iter_reg  <= '0;
            ecnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    assign scan_idx = cnt_reg[NIDX_W-1:0];
    assign out_idx  = cnt_reg[NIDX_W-1:0];
    assign edge_idx = ecnt_reg[EIDX_W-1:0];
    assign out_last = (cnt_reg + 7'd1) == n;
    assign busy     = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        rev_next   = rev_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        ecnt_next  = ecnt_reg;
        cmd        = '0;
        cmd.rev    = rev_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rev_next   = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                cnt_next   = '0;
                iter_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg + 7'd1 == n)
                begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                // The compare for the last node read lands in this cycle.
                state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
            begin
                cmd.scan_end = 1'b1;
                ecnt_next    = '0;
                if (!stat.found)
                begin
                    state_next = ST_EDGE_END;
                end
                else if (edge_total == '0)
                begin
                    state_next = ST_EDGE_END;
                end
                else
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                // One edge read per cycle; the distance read for the previous
                // edge overlaps with this read and its compare follows later.
                cmd.edge_rd    = 1'b1;
                cmd.edge_relax = ecnt_reg != '0;
                ecnt_next      = ecnt_reg + 11'd1;
                if (ecnt_reg + 11'd1 == edge_total)
                begin
                    state_next = ST_EDGE_WAIT;
                end
            end
            ST_EDGE_WAIT:
            begin
                cmd.edge_relax = 1'b1;
                state_next     = ST_EDGE_END;
            end
            ST_EDGE_END:
            begin
                iter_next = iter_reg + 7'd1;
                cnt_next  = '0;
                if (!stat.found || iter_reg + 7'd1 == n)
                begin
                    if (rev_reg)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        rev_next   = 1'b1;
                        state_next = ST_INIT;
                    end
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                    state_next   = out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> hw/rtl/rtsp_dp.sv
module rtsp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rtsp_pkg::cmd_t              cmd,
    input  logic [rtsp_pkg::NODE_W-1:0] n,
    input  logic                        edge_we,
    input  logic [rtsp_pkg::EIDX_W-1:0] edge_waddr,
    input  logic [rtsp_pkg::EDGE_W-1:0] edge_wdata,
    input  logic [rtsp_pkg::NIDX_W-1:0] scan_idx,
    input  logic [rtsp_pkg::EIDX_W-1:0] edge_idx,
    input  logic [rtsp_pkg::NIDX_W-1:0] out_idx,
    input  logic                        out_last,
    input  logic                        overflow,
    output rtsp_pkg::stat_t             stat,
    rtsp_out_if.source                  res
);
    import rtsp_pkg::*;

    logic [MAX_NODES-1:0] reach_reg [2];
    logic [MAX_NODES-1:0] done_reg;
    logic [NIDX_W-1:0]    best_reg;
    logic                 found_reg;
    logic [DIST_W-1:0]    best_d_reg;
    logic [EDGE_W-1:0]    edge_rdata;
    logic [TOTAL_W-1:0]   total_reg;
    logic [DIST_W-1:0]    dt_reg, db_reg;
    logic                 rf_reg, rb_reg;
    logic                 valid_reg;
    out_item_t            data_reg;

    logic                 sc_v_reg;
    logic [NIDX_W-1:0]    sc_idx_reg;
    logic                 s2_reg;
    logic                 src_ok_reg;
    logic [NIDX_W-1:0]    dst_d_reg;
    logic [WEIGHT_W-1:0]  w_d_reg;
    logic                 fwd_v_reg;
    logic [NIDX_W-1:0]    fwd_idx_reg;
    logic [DIST_W-1:0]    fwd_d_reg;
    logic                 out_rd_d_reg;

    logic                 r;
    logic [NODE_W-1:0]    e_src, e_dst;
    logic [NIDX_W-1:0]    dst_i;
    logic                 src_ok;
    logic [NIDX_W-1:0]    dist_raddr;
    logic [NIDX_W-1:0]    dist_waddr;
    logic [DIST_W-1:0]    dist_wdata;
    logic                 dist_we_f, dist_we_r;
    logic [DIST_W-1:0]    dist_f_rdata, dist_r_rdata;
    logic [DIST_W-1:0]    dist_q, dist_cur;
    logic [DIST_W:0]      cand;
    logic                 relax_ok;
    logic                 relax_we;
    logic                 s_ok;
    logic [DIST_W-1:0]    dt, db;
    logic [TOTAL_W-1:0]   tot_next;

    assign r = cmd.rev;

    rtsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
        .clk  (clk),
        .we   (edge_we),
        .waddr(edge_waddr),
        .wdata(edge_wdata),
        .raddr(edge_idx),
        .rdata(edge_rdata)
    );

    rtsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_f (
        .clk  (clk),
        .we   (dist_we_f),
        .waddr(dist_waddr),
        .wdata(dist_wdata),
        .raddr(dist_raddr),
        .rdata(dist_f_rdata)
    );

    rtsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_r (
        .clk  (clk),
        .we   (dist_we_r),
        .waddr(dist_waddr),
        .wdata(dist_wdata),
        .raddr(dist_raddr),
        .rdata(dist_r_rdata)
    );

    always_comb
    begin
        e_src = r ? edge_rdata[EDGE_W-NODE_W-1 -: NODE_W]
                  : edge_rdata[EDGE_W-1 -: NODE_W];
        e_dst = r ? edge_rdata[EDGE_W-1 -: NODE_W]
                  : edge_rdata[EDGE_W-NODE_W-1 -: NODE_W];
        dst_i = NIDX_W'(e_dst - 7'd1);
        src_ok = (e_src == {1'b0, best_reg} + 7'd1) && e_dst != '0 && e_dst <= n;
        dist_raddr = cmd.scan ? scan_idx : (cmd.out_rd ? out_idx : dst_i);
        dist_q = r ? dist_r_rdata : dist_f_rdata;
        // A write in the previous cycle is not yet seen by the registered read.
        dist_cur = (fwd_v_reg && fwd_idx_reg == dst_d_reg) ? fwd_d_reg : dist_q;
        cand  = {1'b0, best_d_reg} + (DIST_W+1)'(w_d_reg);
        relax_ok = src_ok_reg
                   && (!reach_reg[r][dst_d_reg] || cand < {1'b0, dist_cur});
        relax_we = s2_reg && relax_ok;
        s_ok = reach_reg[r][sc_idx_reg] && !done_reg[sc_idx_reg]
               && (sc_idx_reg == '0 || !found_reg || dist_q < best_d_reg);
        dist_waddr = cmd.init ? '0 : dst_d_reg;
        dist_wdata = cmd.init ? '0 : cand[DIST_W-1:0];
        dist_we_f  = (cmd.init || relax_we) && !r;
        dist_we_r  = (cmd.init || relax_we) && r;
        dt = rf_reg ? dt_reg : '0;
        db = rb_reg ? db_reg : '0;
        tot_next = total_reg + TOTAL_W'(dt) + TOTAL_W'(db);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg[0] <= '0;
            reach_reg[1] <= '0;
            done_reg     <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_d_reg   <= '0;
            valid_reg    <= 1'b0;
            total_reg    <= '0;
            dt_reg       <= '0;
            db_reg       <= '0;
            rf_reg       <= 1'b0;
            rb_reg       <= 1'b0;
            data_reg     <= '0;
            sc_v_reg     <= 1'b0;
            sc_idx_reg   <= '0;
            s2_reg       <= 1'b0;
            src_ok_reg   <= 1'b0;
            dst_d_reg    <= '0;
            w_d_reg      <= '0;
            fwd_v_reg    <= 1'b0;
            fwd_idx_reg  <= '0;
            fwd_d_reg    <= '0;
            out_rd_d_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                reach_reg[r] <= {{(MAX_NODES-1){1'b0}}, 1'b1};
                done_reg     <= '0;
                total_reg    <= '0;
            end
            // The compare runs in the cycle after the distance read; node 0
            // starts a fresh search round.
            if (cmd.init)
            begin
                found_reg <= 1'b0;
            end
            else if (sc_v_reg)
            begin
                if (s_ok)
                begin
                    found_reg  <= 1'b1;
                    best_reg   <= sc_idx_reg;
                    best_d_reg <= dist_q;
                end
                else if (sc_idx_reg == '0)
                begin
                    found_reg <= 1'b0;
                end
            end
            sc_v_reg   <= cmd.scan;
            sc_idx_reg <= scan_idx;
            if (cmd.scan_end && found_reg)
            begin
                done_reg[best_reg] <= 1'b1;
            end
            s2_reg     <= cmd.edge_relax;
            src_ok_reg <= src_ok;
            dst_d_reg  <= dst_i;
            w_d_reg    <= edge_rdata[WEIGHT_W-1:0];
            if (relax_we)
            begin
                reach_reg[r][dst_d_reg] <= 1'b1;
            end
            fwd_v_reg   <= relax_we;
            fwd_idx_reg <= dst_d_reg;
            fwd_d_reg   <= cand[DIST_W-1:0];
            out_rd_d_reg <= cmd.out_rd;
            if (cmd.out_rd)
            begin
                rf_reg <= reach_reg[0][out_idx];
                rb_reg <= reach_reg[1][out_idx];
            end
            if (out_rd_d_reg)
            begin
                dt_reg <= dist_f_rdata;
                db_reg <= dist_r_rdata;
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
                total_reg <= tot_next;
                data_reg.node             <= {1'b0, out_idx} + 7'd1;
                data_reg.dist_there       <= dt;
                data_reg.dist_back        <= db;
                data_reg.there_reached    <= rf_reg;
                data_reg.back_reached     <= rb_reg;
                data_reg.round_trip_total <= out_last ? tot_next : '0;
                data_reg.edge_overflow    <= overflow;
                data_reg.last             <= out_last;
            end
            else if (res.valid && res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign stat.found    = found_reg;
    assign stat.out_full = valid_reg && !res.ready;
    assign res.valid     = valid_reg;
    assign res.data      = data_reg;
endmodule

>>> hw/rtl/round_trip_shortest_paths_top.sv
// Channel  Dir  Handshake      Payload
// in       in   valid/ready    kind, from_node, to_node, weight
// res      out  valid/ready    node, distances, reach flags, total, flags
// cfg      in   cfg_we         node_count (7 bits)
// A run item makes two passes, each with one setup step and, per visited
// node, a scan over all n nodes and a sweep over all stored edges (the sweep
// is skipped when there are no edges or no node is left), then sends one
// result per node; the single edge memory read port sets the sweep's pace.
// Reset clears the edge count, flags and control; no clearing pass is needed.
// A stalled result register holds the sequencer until the result is taken.
module round_trip_shortest_paths_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rtsp_pkg::NODE_W-1:0]  cfg_wdata,
    rtsp_in_if.sink                      in,
    rtsp_out_if.source                   res
);
    import rtsp_pkg::*;

    logic [NODE_W-1:0] cnt_cfg_reg;
    logic [ECNT_W-1:0] etot_reg;
    logic              ovf_reg;
    logic [NODE_W-1:0] n;
    cmd_t              cmd;
    stat_t             stat;
    logic              busy, start, acc, add_ok, out_last;
    logic [NIDX_W-1:0] scan_idx, out_idx;
    logic [EIDX_W-1:0] edge_idx;

    assign n = (cnt_cfg_reg == '0) ? 7'd1 :
               (cnt_cfg_reg > 7'(MAX_NODES)) ? 7'(MAX_NODES) : cnt_cfg_reg;
    assign in.ready = !busy;
    assign acc   = in.valid && in.ready;
    assign start = acc && in.data.kind == KIND_RUN;
    assign add_ok = acc && in.data.kind == KIND_ADD
                    && in.data.from_node != '0 && in.data.from_node <= n
                    && in.data.to_node != '0 && in.data.to_node <= n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_cfg_reg <= 7'(MAX_NODES);
            etot_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_cfg_reg <= cfg_wdata;
            end
            if (acc && in.data.kind == KIND_CLEAR)
            begin
                etot_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (add_ok)
            begin
                if (etot_reg >= ECNT_W'(MAX_EDGES))
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    etot_reg <= etot_reg + 11'd1;
                end
            end
        end
    end

    rtsp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .n(n), .edge_total(etot_reg),
        .stat(stat), .cmd(cmd), .busy(busy), .scan_idx(scan_idx),
        .edge_idx(edge_idx), .out_idx(out_idx), .out_last(out_last)
    );

    rtsp_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .n(n),
        .edge_we(add_ok && etot_reg < ECNT_W'(MAX_EDGES)),
        .edge_waddr(etot_reg[EIDX_W-1:0]),
        .edge_wdata({in.data.from_node, in.data.to_node, in.data.weight}),
        .scan_idx(scan_idx), .edge_idx(edge_idx), .out_idx(out_idx),
        .out_last(out_last), .overflow(ovf_reg), .stat(stat), .res(res)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in.ready) else $error("input taken during a run");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        etot_reg <= ECNT_W'(MAX_EDGES)) else $error("edge count overran");
    a_last_total: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.data.last) |-> res.data.round_trip_total == '0)
        else $error("total on a non-final result");
endmodule
